// ===== sv/barometric_sensor_compensation_macros.svh =====
// Assertion macros for the barometric compensation block.
`ifndef BAROMETRIC_SENSOR_COMPENSATION_MACROS_SVH
`define BAROMETRIC_SENSOR_COMPENSATION_MACROS_SVH
`ifndef ASSERT_OFF
`define BSC_ASSERT_IMPL(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define BSC_ASSERT(label, prop, msg) \
    `BSC_ASSERT_IMPL(label, aclk, aresetn, prop, msg)
`else
`define BSC_ASSERT_IMPL(label, clk, rstn, prop, msg)
`define BSC_ASSERT(label, prop, msg)
`endif
`endif

// ===== sv/bsc_pkg.sv =====
// Package: payload types, constants and arithmetic helpers for the compensation block.
`default_nettype none
package bsc_pkg;
    localparam int CfgIdxW = 2;
    localparam int CfgW    = 48;
    localparam logic [CfgIdxW-1:0] REG_TEMP    = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_PRESS_A = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_PRESS_B = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_PRESS_C = 2'd3;
    localparam logic [31:0] OFFSET_FINE = 32'd64000;
    localparam logic [31:0] PRESS_BASE  = 32'd1048576;
    localparam logic [31:0] PRESS_SCALE = 32'd3125;
    localparam logic [31:0] SIGN_BIT    = 32'h80000000;
    localparam logic [31:0] P1_BIAS     = 32'd32768;
    localparam logic [31:0] ROUND_T     = 32'd128;
    localparam int DivSteps = 32;
    localparam int DivTagW  = 34;

    typedef struct packed {
        logic [19:0] raw_temp;
        logic [19:0] press_adc;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] temp_centi;
        logic [31:0]        pressure_pa;
        logic               pressure_invalid;
    } out_item_t;

    function automatic logic [31:0] mulw(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = {32'd0, a} * {32'd0, b};
        return p[31:0];
    endfunction

    function automatic logic [31:0] asr(input logic [31:0] x, input int n);
        return 32'($signed(x) >>> n);
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction
endpackage
`default_nettype wire

// ===== sv/bsc_div.sv =====
// Pipelined 32-bit restoring unsigned divider, one quotient bit per stage.
`default_nettype none
module bsc_div
    import bsc_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               adv,
    input  wire logic               in_vld,
    input  wire logic [31:0]        in_num,
    input  wire logic [31:0]        in_den,
    input  wire logic [DivTagW-1:0] in_tag,
    output logic                    out_vld,
    output logic [31:0]             out_quo,
    output logic [DivTagW-1:0]      out_tag
);
    logic                vld_reg [1:DivSteps];
    logic [31:0]         num_reg [1:DivSteps];
    logic [31:0]         den_reg [1:DivSteps];
    logic [31:0]         rem_reg [1:DivSteps];
    logic [DivTagW-1:0]  tag_reg [1:DivSteps];

    for (genvar i = 0; i < DivSteps; i++) begin : g_step
        logic               vld_c;
        logic [31:0]        num_c;
        logic [31:0]        den_c;
        logic [31:0]        rem_c;
        logic [DivTagW-1:0] tag_c;
        logic [32:0]        sh;
        logic [32:0]        df;
        logic               ge;
        if (i == 0) begin : g_first
            assign vld_c = in_vld;
            assign num_c = in_num;
            assign den_c = in_den;
            assign rem_c = '0;
            assign tag_c = in_tag;
        end else begin : g_next
            assign vld_c = vld_reg[i];
            assign num_c = num_reg[i];
            assign den_c = den_reg[i];
            assign rem_c = rem_reg[i];
            assign tag_c = tag_reg[i];
        end
        always_comb begin
            sh = {rem_c, num_c[31]};
            df = sh - {1'b0, den_c};
            ge = !df[32];
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i+1] <= 1'b0;
            end else if (adv) begin
                vld_reg[i+1] <= vld_c;
            end
            if (adv) begin
                rem_reg[i+1] <= ge ? df[31:0] : sh[31:0];
                num_reg[i+1] <= {num_c[30:0], ge};
                den_reg[i+1] <= den_c;
                tag_reg[i+1] <= tag_c;
            end
        end
    end

    assign out_vld = vld_reg[DivSteps];
    assign out_quo = num_reg[DivSteps];
    assign out_tag = tag_reg[DivSteps];
endmodule
`default_nettype wire

// ===== sv/barometric_sensor_compensation.sv =====
// Top level: pipelined barometric temperature and pressure compensation.
`default_nettype none
`include "barometric_sensor_compensation_macros.svh"
// One transaction in, one transaction out, one per cycle sustained. The pipe has
// eight arithmetic stages of at most one 32x32 multiply in depth, a 32-stage
// divider pipeline at one quotient bit per stage, and three correction stages.
// The whole pipe advances together; it holds when the output register is full and
// not taken. Calibration must be written through cfg_* while idle; not enforced.
module barometric_sensor_compensation
    import bsc_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic [CfgIdxW-1:0] cfg_idx,
    input  wire logic [CfgW-1:0]    cfg_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire in_item_t           s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output out_item_t               m_data
);
    logic [CfgW-1:0] tcal_reg, pa_reg, pb_reg, pc_reg;
    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tcal_reg <= '0;
            pa_reg   <= '0;
            pb_reg   <= '0;
            pc_reg   <= '0;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                REG_TEMP:    tcal_reg <= cfg_data;
                REG_PRESS_A: pa_reg   <= cfg_data;
                REG_PRESS_B: pb_reg   <= cfg_data;
                REG_PRESS_C: pc_reg   <= cfg_data;
                default:     tcal_reg <= tcal_reg;
            endcase
        end
    end

    assign t1 = {16'd0, tcal_reg[47:32]};
    assign t2 = sx16(tcal_reg[31:16]);
    assign t3 = sx16(tcal_reg[15:0]);
    assign p1 = {16'd0, pa_reg[47:32]};
    assign p2 = sx16(pa_reg[31:16]);
    assign p3 = sx16(pa_reg[15:0]);
    assign p4 = sx16(pb_reg[47:32]);
    assign p5 = sx16(pb_reg[31:16]);
    assign p6 = sx16(pb_reg[15:0]);
    assign p7 = sx16(pc_reg[47:32]);
    assign p8 = sx16(pc_reg[31:16]);
    assign p9 = sx16(pc_reg[15:0]);

    logic adv;
    logic m_valid_reg;
    out_item_t m_data_reg;
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // stage 1: first products
    logic        v1_reg;
    logic [19:0] ap1_reg;
    logic [31:0] a1_reg, dd1_reg;
    // stage 2
    logic        v2_reg;
    logic [19:0] ap2_reg;
    logic [31:0] a2_reg, m2_reg;
    // stage 3: fine
    logic        v3_reg;
    logic [19:0] ap3_reg;
    logic [31:0] fine3_reg;
    // stage 4: tc, a, sq
    logic        v4_reg;
    logic [19:0] ap4_reg;
    logic [31:0] tc4_reg, a4_reg, sq4_reg;
    // stage 5: products of a and sq
    logic        v5_reg;
    logic [19:0] ap5_reg;
    logic [31:0] tc5_reg, b5_reg, a5p5_reg, p3s_reg, p2a_reg;
    // stage 6: b and a sum
    logic        v6_reg;
    logic [19:0] ap6_reg;
    logic [31:0] tc6_reg, b6_reg, x6_reg;
    // stage 7: den
    logic        v7_reg;
    logic [31:0] tc7_reg, den7_reg, pr7_reg;
    // stage 8: pr raw
    logic        v8_reg;
    logic [31:0] tc8_reg, den8_reg, pr8_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0; v4_reg <= 1'b0;
            v5_reg <= 1'b0; v6_reg <= 1'b0; v7_reg <= 1'b0; v8_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid; v2_reg <= v1_reg; v3_reg <= v2_reg; v4_reg <= v3_reg;
            v5_reg <= v4_reg; v6_reg <= v5_reg; v7_reg <= v6_reg; v8_reg <= v7_reg;
        end
        if (adv) begin
            ap1_reg <= s_data.press_adc;
            a1_reg  <= asr(mulw({15'd0, s_data.raw_temp[19:3]} - (t1 << 1), t2), 11);
            dd1_reg <= {16'd0, s_data.raw_temp[19:4]} - t1;
            ap2_reg <= ap1_reg;
            a2_reg  <= a1_reg;
            m2_reg  <= asr(mulw(dd1_reg, dd1_reg), 12);
            ap3_reg <= ap2_reg;
            fine3_reg <= a2_reg + asr(mulw(m2_reg, t3), 14);
            ap4_reg <= ap3_reg;
            tc4_reg <= asr(mulw(fine3_reg, 32'd5) + ROUND_T, 8);
            a4_reg  <= asr(fine3_reg, 1) - OFFSET_FINE;
            sq4_reg <= mulw(asr(asr(fine3_reg, 1) - OFFSET_FINE, 2),
                            asr(asr(fine3_reg, 1) - OFFSET_FINE, 2));
            ap5_reg  <= ap4_reg;
            tc5_reg  <= tc4_reg;
            b5_reg   <= mulw(asr(sq4_reg, 11), p6);
            a5p5_reg <= mulw(a4_reg, p5) << 1;
            p3s_reg  <= mulw(p3, asr(sq4_reg, 13));
            p2a_reg  <= mulw(p2, a4_reg);
            ap6_reg <= ap5_reg;
            tc6_reg <= tc5_reg;
            b6_reg  <= asr(b5_reg + a5p5_reg, 2) + (p4 << 16);
            x6_reg  <= asr(asr(p3s_reg, 3) + asr(p2a_reg, 1), 18);
            tc7_reg  <= tc6_reg;
            den7_reg <= asr(mulw(P1_BIAS + x6_reg, p1), 15);
            pr7_reg  <= (PRESS_BASE - {12'd0, ap6_reg}) - asr(b6_reg, 12);
            tc8_reg  <= tc7_reg;
            den8_reg <= den7_reg;
            pr8_reg  <= mulw(pr7_reg, PRESS_SCALE);
        end
    end

    logic        big8;
    logic [31:0] num8;
    assign big8 = (pr8_reg & SIGN_BIT) != 32'd0;
    assign num8 = big8 ? pr8_reg : (pr8_reg << 1);

    logic               vd;
    logic [31:0]        qd;
    logic [DivTagW-1:0] tagd;
    bsc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .in_vld  (v8_reg),
        .in_num  (num8),
        .in_den  (den8_reg),
        .in_tag  ({tc8_reg, den8_reg == 32'd0, big8}),
        .out_vld (vd),
        .out_quo (qd),
        .out_tag (tagd)
    );

    // correction stages
    logic        v9_reg, v10_reg;
    logic [31:0] tc9_reg, pr9_reg, tc10_reg, pr10_reg, e9_reg, f9_reg;
    logic [31:0] sq9;
    logic        bad9_reg, bad10_reg;
    logic [31:0] prq;
    assign prq = tagd[0] ? (qd << 1) : qd;
    assign sq9 = mulw({3'd0, prq[31:3]}, {3'd0, prq[31:3]}) >> 13;

    logic [31:0] sqr_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v9_reg <= 1'b0; v10_reg <= 1'b0; m_valid_reg <= 1'b0;
        end else if (adv) begin
            v9_reg <= vd; v10_reg <= v9_reg; m_valid_reg <= v10_reg;
        end
        if (adv) begin
            tc9_reg  <= tagd[33:2];
            bad9_reg <= tagd[1];
            pr9_reg  <= prq;
            sqr_reg  <= sq9;
            f9_reg   <= asr(mulw({2'd0, prq[31:2]}, p8), 13);
            tc10_reg  <= tc9_reg;
            bad10_reg <= bad9_reg;
            pr10_reg  <= pr9_reg;
            e9_reg    <= asr(mulw(p9, sqr_reg), 12) + f9_reg;
            m_data_reg.temp_centi       <= tc10_reg;
            m_data_reg.pressure_invalid <= bad10_reg;
            m_data_reg.pressure_pa      <= bad10_reg ? 32'd0
                                         : pr10_reg + asr(e9_reg + p7, 4);
        end
    end

    `BSC_ASSERT(a_hold_out, m_valid && !m_ready |=> m_valid && $stable(m_data), "output dropped")
    `BSC_ASSERT(a_ready_rule, s_ready == (!m_valid || m_ready), "ready mismatch")
    `BSC_ASSERT(a_bad_zero, m_valid && m_data.pressure_invalid |-> m_data.pressure_pa == 32'd0, "invalid pressure not zero")
endmodule
`default_nettype wire
